[rtl/core/bba_pkg.sv]
// Shared item types and code constants for the buddy block allocator.
package bba_pkg;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_NO_SPACE  = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [31:0] request_size;
        logic [17:0] block_offset;
    } bba_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] granted_offset;
        logic [4:0]  granted_order;
        logic [18:0] bytes_in_use;
    } bba_out_t;

endpackage

[rtl/core/buddy_block_allocator.sv]
// Buddy allocator for one segment: order search, block split, free check and merge.
//
// Usage: present an item on command and pulse start while busy is low; the item
// is taken at that clock edge and busy rises. The block walks the item through a
// small sequencer that reuses one compare/add unit and reads one free-map level
// per cycle. The result appears on result for exactly one cycle with done high,
// in the same cycle that busy falls; the receiver cannot stall it, so capture it
// on that edge. A new item may be started in the done cycle. Steps per item:
// first the order search tries the candidate orders upward from BASE_ORDER
// (L = order - BASE_ORDER). An allocation then takes a space check, a scan
// of the levels upward for a free block and the splits down to the order.
// A free takes an overlap check over every level and then merges upward
// with free buddies, one merge step per level.
// An out-of-range or oversized item finishes right after the order search.
// Offsets are byte offsets; free blocks are taken from the lowest fitting
// level that holds one, lowest offset first within that level.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int BASE_ORDER = 12,
    parameter int LEVELS     = 7
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  bba_in_t  command,
    output logic     busy,
    output logic     done,
    output bba_out_t result
);

    localparam int TOP_ORDER = BASE_ORDER + LEVELS - 1;
    localparam int UW        = TOP_ORDER + 1;          // byte counts up to the segment size
    localparam int IW        = LEVELS - 1;             // block index width at level 0
    localparam int NBLK      = 1 << IW;                // blocks at level 0
    localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [UW-1:0] MIN_BYTES = UW'(1) << BASE_ORDER;
    localparam logic [UW-1:0] SEG_BYTES = UW'(1) << TOP_ORDER;
    localparam logic [LW-1:0] LAST_LVL  = LW'(LEVELS - 1);

    typedef logic [NBLK-1:0] row_t;
    typedef logic [IW-1:0]   idx_t;
    typedef logic [LW-1:0]   lvl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIZE,     // find the order: one threshold compare per cycle
        S_CHECK,    // byte budget check for an allocation
        S_SEARCH,   // scan levels upward for a free block
        S_SPLIT,    // split down, freeing each upper half
        S_OVL,      // check that no part of the freed block is already free
        S_MERGE     // merge with free buddies upward
    } state_t;

    state_t       state_reg, state_next;
    logic         op_reg, op_next;
    logic [31:0]  size_reg, size_next;
    logic [17:0]  offs_reg, offs_next;
    lvl_t         lvl_reg, lvl_next;
    lvl_t         j_reg, j_next;
    idx_t         i_reg, i_next;
    logic [UW-1:0] thr_reg, thr_next;
    logic [UW-1:0] used_reg, used_next;
    row_t         fm_reg [LEVELS];
    row_t         fm_next [LEVELS];
    logic         done_reg, done_next;
    bba_out_t     res_reg, res_next;

    // Shared datapath terms
    row_t          row;
    row_t          lowbit;
    idx_t          lowidx;
    idx_t          base0;
    idx_t          hmask;
    lvl_t          mlvl;
    row_t          match_vec;
    logic [UW-1:0] raised;
    logic [UW-1:0] avail;
    logic [4:0]    cur_order;
    logic [17:0]   cur_offset;
    idx_t          buddy;

    function automatic bba_out_t make_result(logic [1:0] st, logic [17:0] off,
                                             logic [4:0] ord, logic [UW-1:0] used);
        bba_out_t r;
        r.status         = st;
        r.granted_offset = off;
        r.granted_order  = ord;
        r.bytes_in_use   = 19'(used);
        return r;
    endfunction

    assign row       = fm_reg[j_reg];
    assign lowbit    = row & (~row + row_t'(1));
    assign base0     = idx_t'(i_reg << lvl_reg);
    assign mlvl      = (j_reg > lvl_reg) ? j_reg : lvl_reg;
    assign hmask     = ~((idx_t'(1) << mlvl) - idx_t'(1));
    assign raised    = (size_reg < 32'(MIN_BYTES)) ? MIN_BYTES : UW'(size_reg);
    assign avail     = SEG_BYTES - used_reg;
    assign cur_order = 5'(BASE_ORDER) + 5'(lvl_reg);
    assign cur_offset = 18'((UW'(base0)) << BASE_ORDER);
    assign buddy     = i_reg ^ idx_t'(1);

    // Encode the lowest set bit of the selected row
    always_comb
    begin
        lowidx = '0;
        for (int k = 0; k < NBLK; k++)
        begin
            if (lowbit[k])
            begin
                lowidx = lowidx | idx_t'(k);
            end
        end
    end

    // Mark every block of the selected level that overlaps the block being freed
    always_comb
    begin
        for (int k = 0; k < NBLK; k++)
        begin
            match_vec[k] = (((idx_t'(k) << j_reg) ^ base0) & hmask) == '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        size_next  = size_reg;
        offs_next  = offs_reg;
        lvl_next   = lvl_reg;
        j_next     = j_reg;
        i_next     = i_reg;
        thr_next   = thr_reg;
        used_next  = used_reg;
        for (int k = 0; k < LEVELS; k++)
        begin
            fm_next[k] = fm_reg[k];
        end
        done_next  = 1'b0;
        res_next   = res_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = command.operation;
                    size_next  = command.request_size;
                    offs_next  = command.block_offset;
                    lvl_next   = '0;
                    thr_next   = MIN_BYTES;
                    state_next = S_SIZE;
                end
            end

            S_SIZE:
            begin
                if (32'(thr_reg) >= size_reg)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        state_next = S_CHECK;
                    end
                    else if ((32'(offs_reg) >> TOP_ORDER) != 32'd0)
                    begin
                        // block index beyond the segment
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        res_next   = make_result(STATUS_NO_SPACE, '0, '0, used_reg);
                    end
                    else
                    begin
                        i_next     = idx_t'((32'(offs_reg) >> BASE_ORDER) >> lvl_reg);
                        j_next     = '0;
                        state_next = S_OVL;
                    end
                end
                else if (lvl_reg == LAST_LVL)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = make_result(STATUS_TOO_LARGE, '0, '0, used_reg);
                end
                else
                begin
                    lvl_next = lvl_reg + lvl_t'(1);
                    thr_next = thr_reg << 1;
                end
            end

            S_CHECK:
            begin
                if (raised > avail)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = make_result(STATUS_NO_SPACE, '0, '0, used_reg);
                end
                else
                begin
                    j_next     = lvl_reg;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (row != '0)
                begin
                    i_next                 = lowidx;
                    fm_next[j_reg][lowidx] = 1'b0;
                    state_next             = S_SPLIT;
                end
                else if (j_reg == LAST_LVL)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = make_result(STATUS_NO_SPACE, '0, '0, used_reg);
                end
                else
                begin
                    j_next = j_reg + lvl_t'(1);
                end
            end

            S_SPLIT:
            begin
                if (j_reg == lvl_reg)
                begin
                    used_next  = used_reg + thr_reg;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = make_result(STATUS_OK, cur_offset, cur_order,
                                             used_reg + thr_reg);
                end
                else
                begin
                    // drop one level, keep the lower half, free the upper half
                    j_next = j_reg - lvl_t'(1);
                    i_next = idx_t'(i_reg << 1);
                    fm_next[j_reg - lvl_t'(1)][idx_t'(i_reg << 1) | idx_t'(1)] = 1'b1;
                end
            end

            S_OVL:
            begin
                if ((row & match_vec) != '0)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = make_result(STATUS_NO_SPACE, '0, '0, used_reg);
                end
                else if (j_reg == LAST_LVL)
                begin
                    j_next     = lvl_reg;
                    state_next = S_MERGE;
                end
                else
                begin
                    j_next = j_reg + lvl_t'(1);
                end
            end

            S_MERGE:
            begin
                if (j_reg != LAST_LVL && fm_reg[j_reg][buddy])
                begin
                    fm_next[j_reg][buddy] = 1'b0;
                    i_next = i_reg >> 1;
                    j_next = j_reg + lvl_t'(1);
                end
                else
                begin
                    fm_next[j_reg][i_reg] = 1'b1;
                    used_next  = (used_reg >= thr_reg) ? (used_reg - thr_reg) : '0;
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    res_next   = make_result(STATUS_OK, '0, cur_order,
                                             (used_reg >= thr_reg) ? (used_reg - thr_reg) : '0);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ALLOC;
            size_reg  <= '0;
            offs_reg  <= '0;
            lvl_reg   <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            thr_reg   <= '0;
            used_reg  <= '0;
            for (int k = 0; k < LEVELS - 1; k++)
            begin
                fm_reg[k] <= '0;
            end
            fm_reg[LEVELS-1] <= row_t'(1);
            done_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            size_reg  <= size_next;
            offs_reg  <= offs_next;
            lvl_reg   <= lvl_next;
            j_reg     <= j_next;
            i_reg     <= i_next;
            thr_reg   <= thr_next;
            used_reg  <= used_next;
            for (int k = 0; k < LEVELS; k++)
            begin
                fm_reg[k] <= fm_next[k];
            end
            done_reg  <= done_next;
            res_reg   <= res_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

[rtl/core/bba_checker.sv]
// Port-level checks for the buddy block allocator and their bind.
module bba_checker
    import bba_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input bba_in_t  command,
    input logic     busy,
    input logic     done,
    input bba_out_t result
);

    // an accepted item always occupies the block
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // the result strobe comes with the block going idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    // every finished item delivers a result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("item finished without a result");

    // a refused item grants nothing
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STATUS_OK) |->
            (result.granted_offset == 18'd0 && result.granted_order == 5'd0))
        else $error("refused item reports a grant");

    // a free item is still in progress in the cycle after it is taken
    a_free_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command.operation == OP_FREE) |=>
            (busy && !done))
        else $error("free item finished too early");

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .command (command),
    .busy    (busy),
    .done    (done),
    .result  (result)
);
